/* rtl/prdpe_pkg.sv */
// Shared types and constants of the PNG row decimating pixel expander.
package prdpe_pkg;

  // Depth of the command queue between the front and the back end.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QLW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_STEP_X        = 3'd0,
    CFG_STEP_Y        = 3'd1,
    CFG_PIXEL_FORMAT  = 3'd2,
    CFG_GRAY_BITS     = 3'd3,
    CFG_PALETTE_ALPHA = 3'd4,
    CFG_KEEP_INDEX    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FMT_RGB     = 2'd0,
    FMT_RGBA    = 2'd1,
    FMT_INDEXED = 2'd2,
    FMT_GRAY    = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    GRAY_8 = 2'd0,
    GRAY_4 = 2'd1,
    GRAY_1 = 2'd2
  } gray_e;

  // How the back end expands one queued command.
  typedef enum logic [1:0] {
    MODE_ONE   = 2'd0,
    MODE_GRAY4 = 2'd1,
    MODE_GRAY1 = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  red;     // gray byte for the packed modes
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  index;
    logic [11:0] x;
    logic [11:0] y;
    logic [2:0]  cnt_m1;  // pixels to emit, minus one
  } cmd_t;

endpackage

/* rtl/prdpe_ram.sv */
// Generic single write, single read RAM with registered read data.
module prdpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/prdpe_front.sv */
// Front end: configuration, row and column accumulators, palette, command build.
module prdpe_front #(
  parameter int MAX_DIM       = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [16:0]           cfg_data_i,
  input  logic                  push_i,
  input  logic                  func_i,
  input  logic                  row_start_i,
  input  logic [7:0]            byte_zero_i,
  input  logic [7:0]            byte_one_i,
  input  logic [7:0]            byte_two_i,
  input  logic [7:0]            byte_three_i,
  input  logic [7:0]            entry_i,
  output logic                  full_o,
  input  logic [prdpe_pkg::QLW-1:0] q_level_i,
  output logic                  q_push_o,
  output prdpe_pkg::cmd_t       q_data_o,
  output logic                  s1_valid_o
);

  localparam int DW  = $clog2(MAX_DIM);
  localparam int RAW = DW + 18;
  localparam int IW  = RAW - 16;
  localparam int CW  = $clog2(MAX_DIM + 1);
  localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic signed [RAW-1:0] ACC_INIT = RAW'(-65536);
  localparam logic signed [RAW-1:0] ROW_LIM  = RAW'(longint'(MAX_DIM) <<< 16);
  localparam logic signed [IW-1:0]  MAX_I    = IW'(MAX_DIM);
  localparam int QLW_SUM = prdpe_pkg::QLW + 1;

  // configuration
  logic [16:0]       step_x_q, step_y_q;
  prdpe_pkg::fmt_e   fmt_q;
  prdpe_pkg::gray_e  gray_q;
  logic              pal_alpha_q, keep_idx_q;
  logic              cfg_we;

  // accumulator state
  logic signed [RAW-1:0] row_acc_q, row_acc_d;
  logic [27:0]           col_acc_q, col_acc_d;
  logic                  row_kept_q, row_kept_d;
  logic [CW-1:0]         col_out_q, col_out_d;
  logic                  skip_q, skip_d;

  // stage between acceptance and the queue, waits on the palette read
  logic                  s1_valid_q;
  prdpe_pkg::cmd_t       s1_cmd_q, s1_cmd_d;
  logic                  s1_pal_q, s1_pal_d;
  logic                  s1_hit_q, s1_hit_d;
  logic                  s1_palpha_q;

  logic                  acc_pix, acc_pal, emit_ok, sampled;
  logic signed [RAW-1:0] sy_ext, acc_add, acc_new;
  logic signed [IW-1:0]  old_int, new_int, cur_int;
  logic                  kept_new, cur_kept, cur_skip;
  logic [CW-1:0]         cur_col, col_sum;
  logic [27:0]           col_step, col_acc_nx;
  logic [3:0]            npix, nres;
  logic [CW:0]           rem;
  logic [31:0]           row_w, col_w;
  logic [QLW_SUM-1:0]    occ;
  logic                  pal_wr_ok, pal_rd_ok;
  logic [31:0]           pal_rdata;

  assign cfg_we = cfg_valid_i && cfg_ready_i;

  // Hold off new items while the queue could not take what is in flight.
  assign occ    = QLW_SUM'(q_level_i) + QLW_SUM'(s1_valid_q);
  assign full_o = occ >= QLW_SUM'(prdpe_pkg::QDEPTH);

  assign acc_pix = push_i && !full_o && !func_i;
  assign acc_pal = push_i && !full_o && func_i;

  assign pal_wr_ok = {1'b0, entry_i} < 9'(PALETTE_DEPTH);
  assign pal_rd_ok = {1'b0, byte_zero_i} < 9'(PALETTE_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q    <= 17'h10000;
      step_y_q    <= 17'h10000;
      fmt_q       <= prdpe_pkg::FMT_RGB;
      gray_q      <= prdpe_pkg::GRAY_8;
      pal_alpha_q <= 1'b0;
      keep_idx_q  <= 1'b0;
    end else if (cfg_we) begin
      case (prdpe_pkg::cfg_idx_e'(cfg_index_i))
        prdpe_pkg::CFG_STEP_X:        step_x_q    <= cfg_data_i;
        prdpe_pkg::CFG_STEP_Y:        step_y_q    <= cfg_data_i;
        prdpe_pkg::CFG_PIXEL_FORMAT:  fmt_q       <= prdpe_pkg::fmt_e'(cfg_data_i[1:0]);
        prdpe_pkg::CFG_GRAY_BITS:     gray_q      <= prdpe_pkg::gray_e'(cfg_data_i[1:0]);
        prdpe_pkg::CFG_PALETTE_ALPHA: pal_alpha_q <= cfg_data_i[0];
        prdpe_pkg::CFG_KEEP_INDEX:    keep_idx_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sy_ext   = $signed(RAW'(step_y_q));
    acc_add  = row_acc_q + sy_ext;
    acc_new  = (row_acc_q < ROW_LIM) ? acc_add : row_acc_q;
    old_int  = $signed(row_acc_q[RAW-1:16]);
    new_int  = $signed(acc_new[RAW-1:16]);
    kept_new = (new_int != old_int) && !new_int[IW-1] && (new_int < MAX_I);
    col_step = col_acc_q + 28'(step_x_q);

    if (row_start_i) begin
      cur_int    = new_int;
      cur_kept   = kept_new;
      cur_col    = '0;
      cur_skip   = 1'b0;
      sampled    = 1'b1;
      col_acc_nx = '0;
    end else begin
      cur_int    = old_int;
      cur_kept   = row_kept_q;
      cur_col    = col_out_q;
      cur_skip   = skip_q;
      sampled    = col_step[27:16] != col_acc_q[27:16];
      col_acc_nx = col_step;
    end

    // pixels this item expands to
    npix = 4'd1;
    if (fmt_q == prdpe_pkg::FMT_GRAY) begin
      case (gray_q)
        prdpe_pkg::GRAY_8: npix = 4'd1;
        prdpe_pkg::GRAY_4: npix = 4'd2;
        prdpe_pkg::GRAY_1: npix = 4'd8;
        default:           npix = 4'd0;
      endcase
    end

    // clip at the row end
    rem     = (CW+1)'(MAX_DIM) - (CW+1)'(cur_col);
    nres    = ((CW+1)'(npix) < rem) ? npix : rem[3:0];
    col_sum = cur_col + CW'(nres);
    emit_ok = cur_kept && sampled && !cur_skip;

    row_w = 32'(cur_int);
    col_w = 32'(cur_col);

    s1_cmd_d        = '0;
    s1_cmd_d.mode   = prdpe_pkg::MODE_ONE;
    s1_cmd_d.x      = col_w[11:0];
    s1_cmd_d.y      = row_w[11:0];
    s1_cmd_d.cnt_m1 = 3'(nres - 4'd1);
    s1_pal_d        = 1'b0;
    s1_hit_d        = pal_rd_ok;
    case (fmt_q)
      prdpe_pkg::FMT_RGB: begin
        s1_cmd_d.red   = byte_zero_i;
        s1_cmd_d.green = byte_one_i;
        s1_cmd_d.blue  = byte_two_i;
        s1_cmd_d.alpha = prdpe_pkg::ALPHA_OPAQUE;
      end
      prdpe_pkg::FMT_RGBA: begin
        s1_cmd_d.red   = byte_zero_i;
        s1_cmd_d.green = byte_one_i;
        s1_cmd_d.blue  = byte_two_i;
        s1_cmd_d.alpha = byte_three_i;
      end
      prdpe_pkg::FMT_INDEXED: begin
        s1_cmd_d.index = byte_zero_i;
        s1_pal_d       = !keep_idx_q;
      end
      default: begin
        s1_cmd_d.red   = byte_zero_i;
        s1_cmd_d.green = byte_zero_i;
        s1_cmd_d.blue  = byte_zero_i;
        s1_cmd_d.alpha = prdpe_pkg::ALPHA_OPAQUE;
        case (gray_q)
          prdpe_pkg::GRAY_4: s1_cmd_d.mode = prdpe_pkg::MODE_GRAY4;
          prdpe_pkg::GRAY_1: s1_cmd_d.mode = prdpe_pkg::MODE_GRAY1;
          default:           s1_cmd_d.mode = prdpe_pkg::MODE_ONE;
        endcase
      end
    endcase

    row_acc_d  = row_acc_q;
    row_kept_d = row_kept_q;
    col_acc_d  = col_acc_q;
    col_out_d  = col_out_q;
    skip_d     = skip_q;
    if (cfg_we && (prdpe_pkg::cfg_idx_e'(cfg_index_i) == prdpe_pkg::CFG_STEP_Y)) begin
      // new image: restart the row accumulator one step before row zero
      row_acc_d  = -$signed(RAW'(cfg_data_i));
      row_kept_d = 1'b0;
    end else if (acc_pix) begin
      if (row_start_i) begin
        row_acc_d  = acc_new;
        row_kept_d = kept_new;
      end
      col_acc_d = col_acc_nx;
      col_out_d = emit_ok ? col_sum : cur_col;
      skip_d    = emit_ok ? (col_sum >= CW'(MAX_DIM)) : cur_skip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_acc_q  <= ACC_INIT;
      row_kept_q <= 1'b0;
      col_acc_q  <= '0;
      col_out_q  <= '0;
      skip_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      row_acc_q  <= row_acc_d;
      row_kept_q <= row_kept_d;
      col_acc_q  <= col_acc_d;
      col_out_q  <= col_out_d;
      skip_q     <= skip_d;
      s1_valid_q <= acc_pix && emit_ok && (nres != 4'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q    <= s1_cmd_d;
    s1_pal_q    <= s1_pal_d;
    s1_hit_q    <= s1_hit_d;
    s1_palpha_q <= pal_alpha_q;
  end

  prdpe_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (acc_pal && pal_wr_ok),
    .waddr_i (entry_i[PAW-1:0]),
    .wdata_i ({byte_zero_i, byte_one_i, byte_two_i, byte_three_i}),
    .re_i    (acc_pix && pal_rd_ok),
    .raddr_i (byte_zero_i[PAW-1:0]),
    .rdata_o (pal_rdata)
  );

  // Merge the palette colour as the command leaves for the queue.
  always_comb begin
    q_data_o = s1_cmd_q;
    if (s1_pal_q) begin
      q_data_o.red   = s1_hit_q ? pal_rdata[31:24] : 8'h00;
      q_data_o.green = s1_hit_q ? pal_rdata[23:16] : 8'h00;
      q_data_o.blue  = s1_hit_q ? pal_rdata[15:8]  : 8'h00;
      q_data_o.alpha = !s1_palpha_q ? prdpe_pkg::ALPHA_OPAQUE :
                       (s1_hit_q ? pal_rdata[7:0] : 8'h00);
    end
  end

  assign q_push_o   = s1_valid_q;
  assign s1_valid_o = s1_valid_q;

endmodule

/* rtl/prdpe_queue.sv */
// Command queue between the front and the back end.
module prdpe_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  prdpe_pkg::cmd_t           data_i,
  input  logic                      pop_i,
  output prdpe_pkg::cmd_t           data_o,
  output logic                      valid_o,
  output logic [prdpe_pkg::QLW-1:0] level_o
);

  prdpe_pkg::cmd_t                  slot_q [prdpe_pkg::QDEPTH];
  logic [prdpe_pkg::QAW-1:0]        wptr_q, rptr_q;
  logic [prdpe_pkg::QLW-1:0]        level_q, level_d;

  always_comb begin
    level_d = level_q;
    if (push_i && !pop_i) begin
      level_d = level_q + 1'b1;
    end else if (pop_i && !push_i) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rptr_q];
  assign valid_o = level_q != '0;
  assign level_o = level_q;

endmodule

/* rtl/prdpe_back.sv */
// Back end: expand queued commands to pixels, one per cycle while the output register is free or drains.
module prdpe_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  prdpe_pkg::cmd_t head_i,
  input  logic            head_valid_i,
  output logic            head_pop_o,
  input  logic            pop_i,
  output logic            out_valid_o,
  output logic [11:0]     dest_x_o,
  output logic [11:0]     dest_y_o,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o,
  output logic [7:0]      alpha_o,
  output logic [7:0]      index_out_o,
  output logic            last_o
);

  logic [2:0]  k_q, k_d;
  logic        out_valid_q, out_valid_d;
  logic        emit, last_pix;
  logic [7:0]  gray_v;
  logic [7:0]  r_v, g_v, b_v;
  logic [2:0]  bit_sel;
  logic [11:0] x_q, y_q;
  logic [7:0]  r_q, g_q, b_q, a_q, i_q;
  logic        last_q;

  // Advance when the output register is free or drains this cycle.
  assign emit     = head_valid_i && (!out_valid_q || pop_i);
  assign last_pix = k_q == head_i.cnt_m1;
  assign bit_sel  = ~k_q;

  always_comb begin
    gray_v = 8'h00;
    r_v    = head_i.red;
    g_v    = head_i.green;
    b_v    = head_i.blue;
    case (head_i.mode)
      prdpe_pkg::MODE_GRAY4: begin
        gray_v = k_q[0] ? {head_i.red[3:0], head_i.red[3:0]}
                        : {head_i.red[7:4], head_i.red[7:4]};
        r_v = gray_v;
        g_v = gray_v;
        b_v = gray_v;
      end
      prdpe_pkg::MODE_GRAY1: begin
        gray_v = {8{head_i.red[bit_sel]}};
        r_v = gray_v;
        g_v = gray_v;
        b_v = gray_v;
      end
      default: ;
    endcase

    k_d = k_q;
    if (emit) begin
      k_d = last_pix ? 3'd0 : k_q + 3'd1;
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      x_q    <= head_i.x + 12'(k_q);
      y_q    <= head_i.y;
      r_q    <= r_v;
      g_q    <= g_v;
      b_q    <= b_v;
      a_q    <= head_i.alpha;
      i_q    <= head_i.index;
      last_q <= last_pix;
    end
  end

  assign head_pop_o  = emit && last_pix;
  assign out_valid_o = out_valid_q;
  assign dest_x_o    = x_q;
  assign dest_y_o    = y_q;
  assign red_o       = r_q;
  assign green_o     = g_q;
  assign blue_o      = b_q;
  assign alpha_o     = a_q;
  assign index_out_o = i_q;
  assign last_o      = last_q;

endmodule

/* rtl/png_row_decimating_pixel_expander.sv */
// An accepted item passes through the stage register and the command queue into the output register,
// and only then is its first pixel on the result ports. The front takes one item per cycle while full
// is low; the back end gives one pixel per cycle while the output register is free or popped, so packed
// gray items (2 or 8 pixels) are absorbed by a 4-entry queue. Palette colours come from a RAM read started
// at acceptance. Reset clears configuration, accumulators, queue and output valid; the palette RAM
// is not cleared and holds whatever was last written.
module png_row_decimating_pixel_expander #(
  parameter int MAX_DIM       = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  // input item side
  input  logic        push,
  output logic        full,
  input  logic        func_i,
  input  logic        row_start_i,
  input  logic [7:0]  byte_zero_i,
  input  logic [7:0]  byte_one_i,
  input  logic [7:0]  byte_two_i,
  input  logic [7:0]  byte_three_i,
  input  logic [7:0]  entry_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [11:0] dest_x_o,
  output logic [11:0] dest_y_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [7:0]  index_out_o,
  output logic        last_o
);

  logic                      q_push, q_pop, q_valid, s1_valid, out_valid;
  prdpe_pkg::cmd_t           q_wdata, q_head;
  logic [prdpe_pkg::QLW-1:0] q_level;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Front: accumulators decide which items produce pixels and how many.
  prdpe_front #(
    .MAX_DIM       (MAX_DIM),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .func_i       (func_i),
    .row_start_i  (row_start_i),
    .byte_zero_i  (byte_zero_i),
    .byte_one_i   (byte_one_i),
    .byte_two_i   (byte_two_i),
    .byte_three_i (byte_three_i),
    .entry_i      (entry_i),
    .full_o       (full),
    .q_level_i    (q_level),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata),
    .s1_valid_o   (s1_valid)
  );

  // Queue decouples the front, which takes one item per cycle while not full, from multi-pixel bursts.
  prdpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .valid_o (q_valid),
    .level_o (q_level)
  );

  // Back: one pixel per cycle into the output register, while it is free or being popped.
  prdpe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .head_valid_i (q_valid),
    .head_pop_o   (q_pop),
    .pop_i        (pop && out_valid),
    .out_valid_o  (out_valid),
    .dest_x_o     (dest_x_o),
    .dest_y_o     (dest_y_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .index_out_o  (index_out_o),
    .last_o       (last_o)
  );

  assign empty = !out_valid;

  // The queue never takes a command while it is already full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_level < prdpe_pkg::QLW'(prdpe_pkg::QDEPTH)))
    else $error("command queue overflow");

  // A palette write never starts a pixel command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && func_i) |=> !s1_valid)
    else $error("palette write produced a command");

  // With nothing in flight the block must take input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_level == '0 && !s1_valid) |-> !full)
    else $error("full raised while idle");

  // The queue is only popped when a command is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty command queue");

endmodule
